// ===== src/a2r_pkg.sv =====
// shared types and constants for the absolute to relative wrap delta block
`default_nettype none

package a2r_pkg;

  // command codes carried in the input tuser
  localparam logic [1:0] CMD_MOVE   = 2'd0;
  localparam logic [1:0] CMD_INJECT = 2'd1;
  localparam logic [1:0] CMD_OTHER  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd0;
  localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd1;
  localparam logic [1:0] REG_WRAP_LIMIT_X  = 2'd2;
  localparam logic [1:0] REG_WRAP_LIMIT_Y  = 2'd3;

  // configuration reset values
  localparam logic [15:0] SCREEN_WIDTH_RST  = 16'd1920;
  localparam logic [15:0] SCREEN_HEIGHT_RST = 16'd1080;
  localparam logic [15:0] WRAP_LIMIT_X_RST  = 16'd960;
  localparam logic [15:0] WRAP_LIMIT_Y_RST  = 16'd540;

  // width of the full precision wrap corrected delta
  localparam int unsigned DW = 19;

  typedef struct packed {
    logic [15:0] screen_width;
    logic [15:0] screen_height;
    logic [15:0] wrap_limit_x;
    logic [15:0] wrap_limit_y;
  } cfg_t;

  typedef struct packed {
    logic               jump_dropped;
    logic               swallow;
    logic               emit;
    logic signed [15:0] delta_y;
    logic signed [15:0] delta_x;
  } res_t;

endpackage

`default_nettype wire

// ===== src/a2r_cfg.sv =====
// configuration register bank
`default_nettype none

module a2r_cfg (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_we,
  input  wire logic [1:0]    cfg_addr,
  input  wire logic [15:0]   cfg_wdata,
  output a2r_pkg::cfg_t      cfg
);

  a2r_pkg::cfg_t regs;

  // register writes by index
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.screen_width  <= a2r_pkg::SCREEN_WIDTH_RST;
      regs.screen_height <= a2r_pkg::SCREEN_HEIGHT_RST;
      regs.wrap_limit_x  <= a2r_pkg::WRAP_LIMIT_X_RST;
      regs.wrap_limit_y  <= a2r_pkg::WRAP_LIMIT_Y_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        a2r_pkg::REG_SCREEN_WIDTH:  regs.screen_width  <= cfg_wdata;
        a2r_pkg::REG_SCREEN_HEIGHT: regs.screen_height <= cfg_wdata;
        a2r_pkg::REG_WRAP_LIMIT_X:  regs.wrap_limit_x  <= cfg_wdata;
        a2r_pkg::REG_WRAP_LIMIT_Y:  regs.wrap_limit_y  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

`default_nettype wire

// ===== src/a2r_axis.sv =====
// one axis: position difference, wrap correction and jump check
`default_nettype none

module a2r_axis (
  input  wire logic signed [15:0]              pos,
  input  wire logic signed [15:0]              prev_pos,
  input  wire logic signed [15:0]              prev_delta,
  input  wire logic [15:0]                     wrap_limit,
  input  wire logic [15:0]                     size,
  input  wire logic [13:0]                     jump_limit,
  output logic signed [a2r_pkg::DW-1:0]        delta,
  output logic                                 over
);

  logic signed [a2r_pkg::DW-1:0] diff;
  logic signed [a2r_pkg::DW-1:0] lim;
  logic signed [a2r_pkg::DW-1:0] sz;
  logic [a2r_pkg::DW-2:0]        mag;

  // full precision difference
  assign diff = a2r_pkg::DW'(pos) - a2r_pkg::DW'(prev_pos);
  assign lim  = signed'({3'b000, wrap_limit});
  assign sz   = signed'({3'b000, size});

  // wrap across the screen edge against the previous direction
  always_comb begin
    if ((diff < -lim) && (prev_delta > 16'sd0)) begin
      delta = diff + sz;
    end else if ((diff > lim) && (prev_delta < 16'sd0)) begin
      delta = diff - sz;
    end else begin
      delta = diff;
    end
  end

  // magnitude against the jump limit
  always_comb begin
    if (delta[a2r_pkg::DW-1]) begin
      mag = (a2r_pkg::DW-1)'(-delta);
    end else begin
      mag = delta[a2r_pkg::DW-2:0];
    end
  end

  assign over = mag > {4'b0000, jump_limit};

endmodule

`default_nettype wire

// ===== src/a2r_core.sv =====
// tracking state and per item decision
`default_nettype none

module a2r_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               step,
  input  wire logic [1:0]         cmd,
  input  wire logic signed [15:0] pos_x,
  input  wire logic signed [15:0] pos_y,
  input  wire a2r_pkg::cfg_t      cfg,
  output a2r_pkg::res_t           res
);

  logic signed [15:0] prev_x;
  logic signed [15:0] prev_y;
  logic signed [15:0] prev_delta_x;
  logic signed [15:0] prev_delta_y;
  logic               awaiting_first;

  logic signed [a2r_pkg::DW-1:0] dx;
  logic signed [a2r_pkg::DW-1:0] dy;
  logic                          over_x;
  logic                          over_y;
  logic                          dropped;
  logic                          moving;
  logic                          tracked;

  a2r_axis u_axis_x (
    .pos        (pos_x),
    .prev_pos   (prev_x),
    .prev_delta (prev_delta_x),
    .wrap_limit (cfg.wrap_limit_x),
    .size       (cfg.screen_width),
    .jump_limit (cfg.screen_width[15:2]),
    .delta      (dx),
    .over       (over_x)
  );

  a2r_axis u_axis_y (
    .pos        (pos_y),
    .prev_pos   (prev_y),
    .prev_delta (prev_delta_y),
    .wrap_limit (cfg.wrap_limit_y),
    .size       (cfg.screen_height),
    .jump_limit (cfg.screen_width[15:2]),
    .delta      (dy),
    .over       (over_y)
  );

  // a real move after the first one is tracked
  assign tracked = (cmd == a2r_pkg::CMD_MOVE) && !awaiting_first;
  assign dropped = tracked && (over_x || over_y);
  assign moving  = tracked && !dropped && ((dx != '0) || (dy != '0));

  // result for the item in the input register
  always_comb begin
    res              = '0;
    res.swallow      = (cmd == a2r_pkg::CMD_INJECT);
    res.jump_dropped = dropped;
    res.emit         = moving;
    if (moving) begin
      res.delta_x = dx[15:0];
      res.delta_y = dy[15:0];
    end
  end

  // state update as the item moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_x         <= '0;
      prev_y         <= '0;
      prev_delta_x   <= '0;
      prev_delta_y   <= '0;
      awaiting_first <= 1'b1;
    end else if (step && (cmd == a2r_pkg::CMD_MOVE)) begin
      prev_x         <= pos_x;
      prev_y         <= pos_y;
      awaiting_first <= 1'b0;
      if (tracked) begin
        if (dropped) begin
          prev_delta_x <= '0;
          prev_delta_y <= '0;
        end else begin
          prev_delta_x <= dx[15:0];
          prev_delta_y <= dy[15:0];
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/absolute_to_relative_wrap_delta.sv =====
// top level: input register, decision core and result register
//
// channel   dir  tdata                          tuser
// s_axis    in   pos_x[15:0] pos_y[31:16]       cmd[1:0]
// m_axis    out  delta_x[15:0] delta_y[31:16]   emit[0] swallow[1] jump_dropped[2]
// cfg       in   write enable, 2 bit index, 16 bit data
//
// one item per cycle unless the result stalls
// the input register feeds the subtract, wrap and compare path into the result register
// reset clears both valid flags and the tracking state and reloads the configuration
// a stalled result holds while one more item waits in the input register
`default_nettype none

module absolute_to_relative_wrap_delta (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // pos_x, pos_y
  input  wire logic [1:0]  s_axis_tuser,   // cmd
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // delta_x, delta_y
  output logic [2:0]       m_axis_tuser,   // emit, swallow, jump_dropped
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [15:0] cfg_wdata
);

  a2r_pkg::cfg_t      cfg;
  a2r_pkg::res_t      res;
  a2r_pkg::res_t      out_res;
  logic               in_valid;
  logic [1:0]         in_cmd;
  logic signed [15:0] in_x;
  logic signed [15:0] in_y;
  logic               out_valid;
  logic               advance;
  logic               step;

  a2r_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // handshake between the two registers
  assign advance       = !out_valid || m_axis_tready;
  assign step          = in_valid && advance;
  assign s_axis_tready = !in_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_cmd <= s_axis_tuser;
      in_x   <= s_axis_tdata[15:0];
      in_y   <= s_axis_tdata[31:16];
    end
  end

  a2r_core u_core (
    .clk   (clk),
    .rst   (rst),
    .step  (step),
    .cmd   (in_cmd),
    .pos_x (in_x),
    .pos_y (in_y),
    .cfg   (cfg),
    .res   (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_res.delta_y, out_res.delta_x};
  assign m_axis_tuser  = {out_res.jump_dropped, out_res.swallow, out_res.emit};

endmodule

`default_nettype wire

// ===== src/a2r_checker.sv =====
// port level checks for the wrap delta block and their bind
`default_nettype none

module a2r_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata,
  input wire logic [2:0]  m_axis_tuser
);

  // nothing comes out and the input is open in the cycle after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> (!m_axis_tvalid && s_axis_tready))
    else $error("not idle right after reset");

  // a result carries at most one of emit, swallow and jump drop
  a_one_flag: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> $onehot0(m_axis_tuser))
    else $error("more than one result flag set");

  // deltas are zero unless a move is emitted, and non-zero when it is
  a_delta_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == 32'd0))
    else $error("delta present without emit");

  a_emit_nonzero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata != 32'd0))
    else $error("emit with zero motion");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result changed");

endmodule

bind absolute_to_relative_wrap_delta a2r_checker u_a2r_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
